// File: hw/rtl/dlrt_pkg.sv
// Shared types and codes for the dirty-pinned LRU residency table.
// Used by dlrt_cell, dirty_pinned_lru_residency_table and the testbench; no dependencies.
package dlrt_pkg;

    typedef struct packed {
        logic        valid;
        logic [31:0] id;
        logic [31:0] stamp;
        logic        dirty;
    } t_entry;

    localparam logic [2:0] ACT_LOOKUP = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_DIRTY  = 3'd2;
    localparam logic [2:0] ACT_CLEAR  = 3'd3;
    localparam logic [2:0] ACT_TICK   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
    localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;

endpackage

// File: hw/rtl/dlrt_cell.sv
// One cell of the rotating entry ring of the residency table.
// Depends on dlrt_pkg for the entry type.
module dlrt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic            i_clear,
    input  dlrt_pkg::t_entry i_entry,
    output dlrt_pkg::t_entry o_entry
);

    logic        r_valid;
    logic [31:0] r_id;
    logic [31:0] r_stamp;
    logic        r_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_id    <= i_entry.id;
            r_stamp <= i_entry.stamp;
            r_dirty <= i_entry.dirty;
        end
    end

    assign o_entry = {r_valid, r_id, r_stamp, r_dirty};

endmodule

// File: hw/rtl/dirty_pinned_lru_residency_table.sv
// Top level of the dirty-pinned LRU residency table: control sequencer and
// the ring of dlrt_cell entries. Depends on dlrt_pkg and dlrt_cell.
//
// Usage:
//   Input beats arrive on the s_axis group: tuser carries the action, tdata
//   the object id and insert dirty mark. Each beat yields one result beat on
//   m_axis with status, slot, evicted count and occupancy.
//   The entries sit in a ring of TABLE_DEPTH cells that rotates by one cell
//   per cycle while a scan runs; every scan is one full turn of the ring.
//   Steps: clear, tick and undefined actions go straight to the result;
//   lookup and mark-dirty run a find scan; an insert runs a find scan and a
//   write scan, into a full table after a timeout scan, and with no write
//   scan if no slot is then free. One item is in work at a time; a new beat
//   is taken once the previous item has moved into the output register.
//   The timeout register must be written over the APB port only while the
//   block is idle; the block itself does not enforce it.
//   Reset empties the table, sets time to zero and the timeout to 1000.
//   When the receiver stalls, the result holds in the output register and
//   the block finishes at most one more item before it waits.
module dirty_pinned_lru_residency_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // object_id[31:0], insert_dirty[32], zero pad
    input  logic [2:0]  s_axis_tuser,  // action[2:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // status[1:0], slot[5:2], evicted[10:6], occupancy[15:11]
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TIMEOUT,
        S_FIND,
        S_WRITE,
        S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic [2:0]       r_op;
    logic [31:0]      r_id;
    logic             r_dirty;
    logic [31:0]      r_time, n_time;
    logic [31:0]      r_tmo;
    logic [CW-1:0]    r_occ, n_occ;
    logic [CW-1:0]    r_evict, n_evict;
    logic             r_best_ok, n_best_ok;
    logic [IW-1:0]    r_best, n_best;
    logic [31:0]      r_best_stamp, n_best_stamp;
    logic             r_do_ev, n_do_ev;
    logic             r_match_ok, n_match_ok;
    logic [IW-1:0]    r_match, n_match;
    logic             r_free_ok, n_free_ok;
    logic [IW-1:0]    r_free, n_free;
    logic [IW-1:0]    r_target, n_target;
    logic [1:0]       r_status, n_status;
    logic [IW-1:0]    r_slot, n_slot;
    logic             r_ov;
    logic [15:0]      r_odata;

    logic             w_accept, w_shift, w_clear, w_last, w_hv;
    logic [31:0]      w_age;
    dlrt_pkg::t_entry w_head, w_tail;
    dlrt_pkg::t_entry w_cell [TABLE_DEPTH+1];

    assign pready        = 1'b1;
    assign prdata        = paddr[2] ? 32'd0 : r_tmo;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_clear       = w_accept && (s_axis_tuser == dlrt_pkg::ACT_CLEAR);
    assign w_shift       = (r_state == S_TIMEOUT) || (r_state == S_FIND) ||
                           (r_state == S_WRITE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;

    // Cell i takes from cell i+1; the last cell takes the edited head entry.
    assign w_cell[TABLE_DEPTH] = w_tail;
    assign w_head              = w_cell[0];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_ring
        dlrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_clear (w_clear),
            .i_entry (w_cell[g+1]),
            .o_entry (w_cell[g])
        );
    end

    assign w_last = (r_idx == LAST_IDX);
    assign w_age  = r_time - w_head.stamp;
    assign w_hv   = w_head.valid && !(r_do_ev && (r_idx == r_best));

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_time       = r_time;
        n_occ        = r_occ;
        n_evict      = r_evict;
        n_best_ok    = r_best_ok;
        n_best       = r_best;
        n_best_stamp = r_best_stamp;
        n_do_ev      = r_do_ev;
        n_match_ok   = r_match_ok;
        n_match      = r_match;
        n_free_ok    = r_free_ok;
        n_free       = r_free;
        n_target     = r_target;
        n_status     = r_status;
        n_slot       = r_slot;
        w_tail       = w_head;

        case (r_state)
            S_IDLE: begin
                n_idx      = '0;
                n_evict    = '0;
                n_best_ok  = 1'b0;
                n_do_ev    = 1'b0;
                n_match_ok = 1'b0;
                n_free_ok  = 1'b0;
                n_status   = dlrt_pkg::ST_OK;
                n_slot     = '0;
                if (w_accept) begin
                    n_state = S_FIN;
                    case (s_axis_tuser)
                        dlrt_pkg::ACT_LOOKUP, dlrt_pkg::ACT_DIRTY: n_state = S_FIND;
                        dlrt_pkg::ACT_INSERT: begin
                            n_state = (r_occ == FULL_CNT) ? S_TIMEOUT : S_FIND;
                        end
                        dlrt_pkg::ACT_CLEAR: n_occ = '0;
                        dlrt_pkg::ACT_TICK: begin
                            if (r_time != dlrt_pkg::TIME_MAX) begin
                                n_time = r_time + 32'd1;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_TIMEOUT: begin
                if (w_head.valid && !w_head.dirty) begin
                    if (w_age > r_tmo) begin
                        w_tail.valid = 1'b0;
                        n_evict      = r_evict + CW'(1);
                        n_occ        = r_occ - CW'(1);
                    end else if (!r_best_ok || (w_head.stamp < r_best_stamp)) begin
                        n_best_ok    = 1'b1;
                        n_best       = r_idx;
                        n_best_stamp = w_head.stamp;
                    end
                end
                n_idx = r_idx + IW'(1);
                if (w_last) begin
                    n_idx   = '0;
                    n_do_ev = (n_evict == '0) && n_best_ok;
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                w_tail.valid = w_hv;
                if (r_do_ev && (r_idx == r_best)) begin
                    n_evict = r_evict + CW'(1);
                    n_occ   = r_occ - CW'(1);
                end
                if (w_hv && (w_head.id == r_id) && !r_match_ok) begin
                    n_match_ok = 1'b1;
                    n_match    = r_idx;
                    if (r_op == dlrt_pkg::ACT_LOOKUP) begin
                        w_tail.stamp = r_time;
                    end else if (r_op == dlrt_pkg::ACT_DIRTY) begin
                        w_tail.dirty = 1'b1;
                    end
                end
                if (!w_hv && !r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free    = r_idx;
                end
                n_idx = r_idx + IW'(1);
                if (w_last) begin
                    n_idx   = '0;
                    n_do_ev = 1'b0;
                    if (r_op == dlrt_pkg::ACT_INSERT) begin
                        if (n_match_ok) begin
                            n_target = n_match;
                            n_state  = S_WRITE;
                        end else if (n_free_ok) begin
                            n_target = n_free;
                            n_occ    = n_occ + CW'(1);
                            n_state  = S_WRITE;
                        end else begin
                            n_status = dlrt_pkg::ST_FULL;
                            n_state  = S_FIN;
                        end
                    end else begin
                        n_status = n_match_ok ? dlrt_pkg::ST_OK : dlrt_pkg::ST_NOTFOUND;
                        n_slot   = n_match_ok ? n_match : '0;
                        n_state  = S_FIN;
                    end
                end
            end
            S_WRITE: begin
                if (r_idx == r_target) begin
                    w_tail.valid = 1'b1;
                    w_tail.id    = r_id;
                    w_tail.stamp = r_time;
                    w_tail.dirty = r_dirty;
                end
                n_idx = r_idx + IW'(1);
                if (w_last) begin
                    n_idx   = '0;
                    n_slot  = r_target;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ov || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_time  <= '0;
            r_tmo   <= dlrt_pkg::TIMEOUT_RESET;
            r_occ   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_time  <= n_time;
            r_occ   <= n_occ;
            if (psel && penable && pwrite && !paddr[2]) begin
                r_tmo <= pwdata;
            end
            if (r_state == S_FIN && (!r_ov || m_axis_tready)) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_evict      <= n_evict;
        r_best_ok    <= n_best_ok;
        r_best       <= n_best;
        r_best_stamp <= n_best_stamp;
        r_do_ev      <= n_do_ev;
        r_match_ok   <= n_match_ok;
        r_match      <= n_match;
        r_free_ok    <= n_free_ok;
        r_free       <= n_free;
        r_target     <= n_target;
        r_status     <= n_status;
        r_slot       <= n_slot;
        if (w_accept) begin
            r_op    <= s_axis_tuser;
            r_id    <= s_axis_tdata[31:0];
            r_dirty <= s_axis_tdata[32];
        end
        if (r_state == S_FIN && (!r_ov || m_axis_tready)) begin
            r_odata <= {5'(r_occ), 5'(r_evict), 4'(r_slot), r_status};
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FULL_CNT)
        else $error("occupancy above table depth");

    a_full_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_status == dlrt_pkg::ST_FULL) |-> (r_evict == '0))
        else $error("refused insert reported evictions");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (r_occ == '0))
        else $error("clear did not empty the table");

    a_idle_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_idx == '0))
        else $error("ring not aligned while idle");

endmodule

// File: verif/tb.sv
// Self-checking testbench for dirty_pinned_lru_residency_table.
// Drives action beats and APB timeout writes, predicts every result beat and
// compares it. Depends on dlrt_pkg and the RTL of the table.
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH       = 16;
    localparam int DRAIN_WAIT  = 3 * DEPTH + 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 350;
    localparam int ID_POOL     = 20;

    // Action codes that the block does not define.
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]  action;
        logic [31:0] object_id;
        logic        insert_dirty;
    } t_request;

    typedef struct {
        logic [1:0] status;
        logic [3:0] slot;
        logic [4:0] evicted;
        logic [4:0] occupancy;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // object_id[31:0], insert_dirty[32], zero pad
    logic [2:0]  s_axis_tuser = '0;  // action[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // status[1:0], slot[5:2], evicted[10:6], occupancy[15:11]

    dirty_pinned_lru_residency_table #(.TABLE_DEPTH(DEPTH)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the table.
    logic        tbl_valid [DEPTH];
    logic [31:0] tbl_id    [DEPTH];
    logic [31:0] tbl_stamp [DEPTH];
    logic        tbl_dirty [DEPTH];
    logic [31:0] tbl_now;
    logic [31:0] tbl_timeout;

    t_request pending_requests[$];
    t_outcome expected_outcomes[$];
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       error_count = 0;
    int       cycle_count = 0;
    logic [31:0] id_pool [ID_POOL];

    function automatic int occupied();
        int n = 0;
        for (int i = 0; i < DEPTH; i++) if (tbl_valid[i]) n++;
        return n;
    endfunction

    function automatic int find_slot(logic [31:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_id[i] == id) return i;
        return DEPTH;
    endfunction

    function automatic int evict_for_insert();
        int n = 0;
        int oldest = DEPTH;
        if (occupied() < DEPTH) return 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (tbl_valid[i] && !tbl_dirty[i] && (tbl_now - tbl_stamp[i]) > tbl_timeout) begin
                tbl_valid[i] = 1'b0;
                n++;
            end
        end
        if (occupied() < DEPTH) return n;
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && !tbl_dirty[i])
                if (oldest == DEPTH || tbl_stamp[i] < tbl_stamp[oldest]) oldest = i;
        if (oldest < DEPTH) begin
            tbl_valid[oldest] = 1'b0;
            n++;
        end
        return n;
    endfunction

    function automatic t_outcome table_step(t_request rq);
        t_outcome r;
        int s;
        r.status = dlrt_pkg::ST_OK;
        r.slot = '0;
        r.evicted = '0;
        case (rq.action)
            dlrt_pkg::ACT_LOOKUP: begin
                s = find_slot(rq.object_id);
                if (s < DEPTH) begin
                    tbl_stamp[s] = tbl_now;
                    r.slot = s[3:0];
                end else r.status = dlrt_pkg::ST_NOTFOUND;
            end
            dlrt_pkg::ACT_INSERT: begin
                r.evicted = 5'(evict_for_insert());
                s = find_slot(rq.object_id);
                if (s == DEPTH)
                    for (int i = DEPTH - 1; i >= 0; i--) if (!tbl_valid[i]) s = i;
                if (s < DEPTH) begin
                    tbl_valid[s] = 1'b1;
                    tbl_id[s] = rq.object_id;
                    tbl_dirty[s] = rq.insert_dirty;
                    tbl_stamp[s] = tbl_now;
                    r.slot = s[3:0];
                end else r.status = dlrt_pkg::ST_FULL;
            end
            dlrt_pkg::ACT_DIRTY: begin
                s = find_slot(rq.object_id);
                if (s < DEPTH) begin
                    tbl_dirty[s] = 1'b1;
                    r.slot = s[3:0];
                end else r.status = dlrt_pkg::ST_NOTFOUND;
            end
            dlrt_pkg::ACT_CLEAR: for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
            dlrt_pkg::ACT_TICK: if (tbl_now != dlrt_pkg::TIME_MAX) tbl_now = tbl_now + 32'd1;
            default: ;
        endcase
        r.occupancy = 5'(occupied());
        return r;
    endfunction

    // Driver: at most one nonblocking update of tvalid per edge.
    always @(posedge i_clk) begin
        t_request rq;
        logic holding;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            holding = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                rq.action = s_axis_tuser;
                rq.object_id = s_axis_tdata[31:0];
                rq.insert_dirty = s_axis_tdata[32];
                expected_outcomes.insert(expected_outcomes.size(), table_step(rq));
                holding = 1'b0;
            end
            if (!holding) begin
                if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    rq = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= rq.action;
                    s_axis_tdata <= {7'b0, rq.insert_dirty, rq.object_id};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Monitor.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t unexpected result beat: actual %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                want = expected_outcomes.pop_front();
                check_field("status", want.status, m_axis_tdata[1:0]);
                check_field("slot", want.slot, m_axis_tdata[5:2]);
                check_field("evicted", want.evicted, m_axis_tdata[10:6]);
                check_field("occupancy", want.occupancy, m_axis_tdata[15:11]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_request(logic [2:0] act, logic [31:0] id, logic dirty);
        t_request rq;
        rq.action = act;
        rq.object_id = id;
        rq.insert_dirty = dirty;
        pending_requests.insert(pending_requests.size(), rq);
    endtask

    task automatic wait_idle();
        while (pending_requests.size() > 0 || s_axis_tvalid || expected_outcomes.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tbl_timeout = value;
        @(posedge i_clk);
    endtask

    task automatic add_random_request();
        int pick = $urandom_range(0, 99);
        logic [31:0] id = ($urandom_range(0, 9) == 0) ? $urandom()
                                                       : id_pool[$urandom_range(0, ID_POOL - 1)];
        logic dirty = ($urandom_range(0, 99) < 25);
        logic coin = 1'($urandom_range(0, 1));
        if (pick < 42) push_request(dlrt_pkg::ACT_INSERT, id, dirty);
        else if (pick < 66) push_request(dlrt_pkg::ACT_LOOKUP, id, coin);
        else if (pick < 74) push_request(dlrt_pkg::ACT_DIRTY, id, coin);
        else if (pick < 95) push_request(dlrt_pkg::ACT_TICK, $urandom(), coin);
        else if (pick < 97) push_request(dlrt_pkg::ACT_CLEAR, $urandom(), coin);
        else push_request(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), $urandom(), coin);
    endtask

    initial begin
        logic [31:0] timeouts [5];
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_id[i] = '0;
            tbl_stamp[i] = '0;
            tbl_dirty[i] = 1'b0;
        end
        tbl_now = '0;
        tbl_timeout = dlrt_pkg::TIMEOUT_RESET;
        timeouts[0] = 32'd0;
        timeouts[1] = 32'hFFFF_FFFF;
        timeouts[2] = 32'd5;
        timeouts[3] = 32'd40;
        timeouts[4] = dlrt_pkg::TIMEOUT_RESET;
        for (int i = 0; i < ID_POOL; i++) id_pool[i] = $urandom();
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset timeout.
        push_request(dlrt_pkg::ACT_LOOKUP, 32'h0, 1'b0);
        push_request(dlrt_pkg::ACT_DIRTY, 32'hFFFF_FFFF, 1'b1);
        push_request(dlrt_pkg::ACT_INSERT, 32'h0, 1'b0);
        push_request(dlrt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 1'b1);
        push_request(dlrt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        push_request(dlrt_pkg::ACT_TICK, 32'h0, 1'b0);
        push_request(dlrt_pkg::ACT_INSERT, 32'h0, 1'b1);
        push_request(dlrt_pkg::ACT_DIRTY, 32'h0, 1'b0);
        for (int i = 2; i < DEPTH + 2; i++) push_request(dlrt_pkg::ACT_INSERT, id_pool[i], i[0]);
        push_request(dlrt_pkg::ACT_INSERT, id_pool[2], 1'b0);
        push_request(ACT_SPARE_HI, 32'hA5A5_5A5A, 1'b1);
        push_request(dlrt_pkg::ACT_CLEAR, 32'h0, 1'b0);
        wait_idle();

        for (int phase = 0; phase < 5; phase++) begin
            write_timeout(timeouts[phase]);
            case (phase % 4)
                0: begin send_idle_pct = 0; recv_idle_pct = 0; end
                1: begin send_idle_pct = 62; recv_idle_pct = 0; end
                2: begin send_idle_pct = 0; recv_idle_pct = 62; end
                default: begin send_idle_pct = 30; recv_idle_pct = 30; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) add_random_request();
            wait_idle();
        end

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
